[src/kcd_pkg.sv]
// Shared types and constants of the key change detector.
package kcd_pkg;

    localparam int ROW_LINES = 8;   // width of the sampled row word
    localparam int ROW_IDX_W = 3;   // width of a row number
    localparam int COL_W     = 3;   // width of a column number
    localparam int CFG_W     = 4;   // width of a count register
    localparam int CFG_IDX_W = 2;   // width of a register index

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE = 2'd1;

    localparam logic [CFG_W-1:0] COUNT_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    typedef struct packed {
        logic load;   // latch the input word and its changed rows
        logic emit;   // move the lowest changed row to the output register
    } t_cmd;

    typedef struct packed {
        logic pend_empty;  // no changed row left
        logic pend_last;   // exactly one changed row left
        logic out_free;    // output register can take a word this cycle
    } t_sts;

endpackage

[src/kcd_item_if.sv]
// Input channel: one column scan reading per word.
interface kcd_item_if;
    logic                        valid;
    logic                        ready;
    logic [kcd_pkg::COL_W-1:0]     column;
    logic [kcd_pkg::ROW_LINES-1:0] row_bits;

    modport source (output valid, column, row_bits, input ready);
    modport sink   (input valid, column, row_bits, output ready);
    modport mon    (input valid, ready, column, row_bits);
endinterface

[src/kcd_event_if.sv]
// Output channel: one key event per word.
interface kcd_event_if;
    logic                          valid;
    logic                          ready;
    logic [kcd_pkg::ROW_IDX_W-1:0] key_row;
    logic [kcd_pkg::COL_W-1:0]     key_column;
    logic                          pressed;
    logic                          last;

    modport source (output valid, key_row, key_column, pressed, last, input ready);
    modport sink   (input valid, key_row, key_column, pressed, last, output ready);
    modport mon    (input valid, ready, key_row, key_column, pressed, last);
endinterface

[src/kcd_cfg_if.sv]
// Configuration write channel: register index and data.
interface kcd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [kcd_pkg::CFG_IDX_W-1:0] index;
    logic [kcd_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/kcd_ctrl.sv]
// Controller: sequences load and event emission for one scan reading.
module kcd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_valid,
    output logic          o_item_ready,
    input  kcd_pkg::t_sts i_sts,
    output kcd_pkg::t_cmd o_cmd
);

    kcd_pkg::t_state r_state, n_state;

    assign o_item_ready = (r_state == kcd_pkg::ST_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        case (r_state)
            kcd_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kcd_pkg::ST_EMIT;
                end
            end
            kcd_pkg::ST_EMIT: begin
                if (i_sts.pend_empty) begin
                    n_state = kcd_pkg::ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.pend_last) begin
                        n_state = kcd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = kcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/kcd_datapath.sv]
// Datapath: count registers, pressed-key map, pending changes, output register.
module kcd_datapath #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kcd_pkg::t_cmd                 i_cmd,
    output kcd_pkg::t_sts                 o_sts,
    input  logic [kcd_pkg::COL_W-1:0]     i_column,
    input  logic [kcd_pkg::ROW_LINES-1:0] i_row_bits,
    input  logic                          i_cfg_we,
    input  logic [kcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kcd_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [kcd_pkg::ROW_IDX_W-1:0] o_key_row,
    output logic [kcd_pkg::COL_W-1:0]     o_key_column,
    output logic                          o_pressed,
    output logic                          o_last
);

    localparam int ROW_W     = (MAX_ROWS < kcd_pkg::ROW_LINES) ? MAX_ROWS
                                                                : kcd_pkg::ROW_LINES;
    localparam int COL_LINES = 2 ** kcd_pkg::COL_W;
    localparam int MAP_DEPTH = (MAX_COLUMNS < COL_LINES) ? MAX_COLUMNS : COL_LINES;
    localparam int MAP_IDX_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    logic [kcd_pkg::CFG_W-1:0]     r_rows, r_cols;
    logic [ROW_W-1:0]              r_map [MAP_DEPTH];
    logic [kcd_pkg::ROW_LINES-1:0] r_pend;
    logic [kcd_pkg::ROW_LINES-1:0] r_bits;
    logic [kcd_pkg::COL_W-1:0]     r_col;
    logic                          r_ov;
    logic [kcd_pkg::ROW_IDX_W-1:0] r_key_row;
    logic [kcd_pkg::COL_W-1:0]     r_key_col;
    logic                          r_pressed, r_last;

    logic [kcd_pkg::ROW_LINES-1:0] row_mask, stored, n_word, low, rest;
    logic [kcd_pkg::ROW_IDX_W-1:0] low_idx;
    logic [MAP_IDX_W-1:0]          map_idx;
    logic                          col_ok;

    // Examined rows: below the row count and below the stored map width.
    always_comb begin
        for (int j = 0; j < kcd_pkg::ROW_LINES; j++) begin
            row_mask[j] = (kcd_pkg::CFG_W'(j) < r_rows) && (j < ROW_W);
        end
    end

    assign col_ok  = ({1'b0, i_column} < r_cols) && (int'(i_column) < MAP_DEPTH);
    assign map_idx = MAP_IDX_W'(i_column);
    assign stored  = col_ok ? kcd_pkg::ROW_LINES'(r_map[map_idx]) : '0;
    assign n_word  = (stored & ~row_mask) | (i_row_bits & row_mask);

    // Lowest pending row and what remains after it.
    assign low  = r_pend & kcd_pkg::ROW_LINES'(~r_pend + 1'b1);
    assign rest = r_pend & ~low;

    always_comb begin
        low_idx = '0;
        for (int j = kcd_pkg::ROW_LINES - 1; j >= 0; j--) begin
            if (r_pend[j]) begin
                low_idx = kcd_pkg::ROW_IDX_W'(j);
            end
        end
    end

    assign o_sts.pend_empty = (r_pend == '0);
    assign o_sts.pend_last  = (r_pend != '0) && (rest == '0);
    assign o_sts.out_free   = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= kcd_pkg::COUNT_RESET;
            r_cols <= kcd_pkg::COUNT_RESET;
            r_pend <= '0;
            r_ov   <= 1'b0;
            for (int c = 0; c < MAP_DEPTH; c++) begin
                r_map[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == kcd_pkg::REG_ROWS_IN_USE) begin
                    r_rows <= i_cfg_data;
                end else if (i_cfg_index == kcd_pkg::REG_COLUMNS_IN_USE) begin
                    r_cols <= i_cfg_data;
                end
            end
            if (i_cmd.load) begin
                r_pend <= col_ok ? ((i_row_bits ^ stored) & row_mask) : '0;
                if (col_ok) begin
                    r_map[map_idx] <= n_word[ROW_W-1:0];
                end
            end else if (i_cmd.emit) begin
                r_pend <= rest;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers need no reset. The column is copied into the output
    // register so a held word survives the load of the next reading.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col  <= i_column;
            r_bits <= i_row_bits;
        end
        if (i_cmd.emit) begin
            r_key_row <= low_idx;
            r_key_col <= r_col;
            r_pressed <= r_bits[low_idx];
            r_last    <= (rest == '0);
        end
    end

    assign o_out_valid  = r_ov;
    assign o_key_row    = r_key_row;
    assign o_key_column = r_key_col;
    assign o_pressed    = r_pressed;
    assign o_last       = r_last;

endmodule

[src/matrix_key_change_detector.sv]
// An accepted reading's changed rows are registered as pending, then move into
//   the output register lowest first; one changed row drains per cycle unless
//   the receiver holds off an event that is waiting in the output register.
// A reading with no change, or an ignored column, gives nothing.
// Reset (i_rst_n low, synchronous): clears all pressed bits, sets both counts
//   to 8 and drops any pending or held event.
module matrix_key_change_detector #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kcd_item_if.sink         i_item,
    kcd_event_if.source      o_event,
    kcd_cfg_if.sink          i_cfg
);

    kcd_pkg::t_cmd cmd;
    kcd_pkg::t_sts sts;

    // Count registers take a write on every cycle.
    assign i_cfg.ready = 1'b1;

    // Controller: accept a reading, then walk its changed rows out one word
    // at a time. The input stays closed until the last changed row has moved
    // into the output register; that word may still wait there while the next
    // reading is accepted.
    kcd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (i_item.ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // Datapath: on load, compare the reading against the stored bitmap of its
    // column, record the examined rows that differ and write the new bitmap
    // back at once; then emit the pending rows lowest first.
    kcd_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_column     (i_item.column),
        .i_row_bits   (i_item.row_bits),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_out_valid  (o_event.valid),
        .i_out_ready  (o_event.ready),
        .o_key_row    (o_event.key_row),
        .o_key_column (o_event.key_column),
        .o_pressed    (o_event.pressed),
        .o_last       (o_event.last)
    );

endmodule

[src/kcd_checker.sv]
// Port-level checks of the key change detector, bound to the top level.
module kcd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_item_valid,
    input logic                          i_item_ready,
    input logic                          i_event_valid,
    input logic                          i_event_ready,
    input logic [kcd_pkg::ROW_IDX_W-1:0] i_event_key_row,
    input logic [kcd_pkg::COL_W-1:0]     i_event_key_column,
    input logic                          i_event_pressed,
    input logic                          i_event_last
);

    // Hold off new readings right after one is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && i_item_ready |=> !i_item_ready)
        else $error("input ready right after an accepted reading");

    // A non-final event means more rows remain: input must stay closed.
    a_closed_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_event_valid && !i_event_last |-> !i_item_ready)
        else $error("input ready while a reading still has events");

    // Reset drops any held event.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_event_valid)
        else $error("event valid after reset");

    // Stalled event holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_event_valid && !i_event_ready |=> i_event_valid
            && $stable(i_event_key_row) && $stable(i_event_key_column)
            && $stable(i_event_pressed) && $stable(i_event_last))
        else $error("stalled event changed");

endmodule

bind matrix_key_change_detector kcd_checker u_kcd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_item_valid       (i_item.valid),
    .i_item_ready       (i_item.ready),
    .i_event_valid      (o_event.valid),
    .i_event_ready      (o_event.ready),
    .i_event_key_row    (o_event.key_row),
    .i_event_key_column (o_event.key_column),
    .i_event_pressed    (o_event.pressed),
    .i_event_last       (o_event.last)
);
